[sv/diag_transport_segmenter_reassembler_assert.svh]
// Assertion macros shared by the checker of the transport segmenter and reassembler.
`ifndef DIAG_TRANSPORT_SEGMENTER_REASSEMBLER_ASSERT_SVH
`define DIAG_TRANSPORT_SEGMENTER_REASSEMBLER_ASSERT_SVH

// Property checked on every clock edge outside of reset.
`define DTSR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Property checked on every clock edge, reset included.
`define DTSR_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) \
        else $error(msg);

`endif

[sv/dtsr_pkg.sv]
// Package of types, codes and constants for the transport segmenter and reassembler.
`default_nettype none

package dtsr_pkg;

    // Sizing defaults.
    localparam int MAX_REQUEST_BYTES_DEF = 4096;
    localparam int QUEUE_DEPTH           = 2;
    localparam int QPTR_W                = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W                = $clog2(QUEUE_DEPTH + 1);

    // Protocol constants.
    localparam logic [7:0]  PAD_BYTE       = 8'hAA;
    localparam logic [7:0]  NRC_PENDING    = 8'h78;
    localparam logic [7:0]  NEG_RESPONSE   = 8'h7F;
    localparam logic [7:0]  FC_CLEAR_SEND  = 8'h30;
    localparam logic [11:0] TOTAL_MAX      = 12'hFFF;
    localparam logic [3:0]  FRAME_LEN_DATA = 4'd8;
    localparam logic [3:0]  FRAME_LEN_FC   = 4'd3;

    // Protocol control information nibbles.
    localparam logic [3:0] PCI_SF = 4'h0;
    localparam logic [3:0] PCI_FF = 4'h1;
    localparam logic [3:0] PCI_CF = 4'h2;
    localparam logic [3:0] PCI_FC = 4'h3;

    // Input action codes.
    localparam logic [2:0] ACT_CLEAR   = 3'd0;
    localparam logic [2:0] ACT_LOAD    = 3'd1;
    localparam logic [2:0] ACT_TRANSMIT = 3'd2;
    localparam logic [2:0] ACT_FLOW    = 3'd3;
    localparam logic [2:0] ACT_RECEIVE = 3'd4;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_REQUEST_ID     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AWAIT_RESPONSE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_FLOW_CTRL  = 2'd2;
    localparam int CFG_DATA_W = 11;

    // Protocol state as reported in state_out.
    typedef enum logic [2:0] {
        PS_READY       = 3'd0,
        PS_AWAIT_FC    = 3'd1,
        PS_SEND_DATA   = 3'd2,
        PS_AWAIT_REPLY = 3'd3,
        PS_SEND_FC     = 3'd4,
        PS_COMPLETED   = 3'd5,
        PS_ERROR       = 3'd6
    } t_pstate;

    // Sequencer state of the back end.
    typedef enum logic [1:0] {
        BS_IDLE,
        BS_TX,
        BS_RX
    } t_bstate;

    // Classified operation handed from the front end to the back end.
    typedef enum logic [2:0] {
        OP_CLEAR,
        OP_LOAD,
        OP_TX,
        OP_FC,
        OP_RX,
        OP_NONE
    } t_op;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  request_byte;
        logic [28:0] rx_id;
        logic [63:0] rx_data;
    } t_in;

    typedef struct packed {
        logic        frame_valid;
        logic [10:0] frame_id;
        logic [3:0]  frame_len;
        logic [63:0] frame_data;
        logic        reply_byte_valid;
        logic [7:0]  reply_byte;
        logic [11:0] received_total;
        logic [2:0]  state_out;
        logic        last;
    } t_out;

    typedef struct packed {
        logic [10:0] request_id;
        logic        await_response;
        logic        use_flow_control;
    } t_cfg;

    typedef struct packed {
        t_op         op;
        logic [7:0]  request_byte;
        logic        id_match;
        logic [63:0] rx_data;
    } t_cmd;

endpackage

`default_nettype wire

[sv/dtsr_front.sv]
// Front end: accepts input transactions, classifies them and queues them for the back end.
`default_nettype none

module dtsr_front
    import dtsr_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire t_in        i_in,
    input  wire logic [7:0] i_match_id,
    output logic            o_cmd_valid,
    output t_cmd            o_cmd,
    input  wire logic       i_cmd_pop
);

    function automatic logic [QPTR_W-1:0] qptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    t_cmd              r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;
    t_cmd              cls_cmd;
    logic              push;
    logic              pop;

    // Decode the action and compare the low identifier bits once, on entry.
    always_comb begin
        cls_cmd.request_byte = i_in.request_byte;
        cls_cmd.rx_data      = i_in.rx_data;
        cls_cmd.id_match     = (i_in.rx_id[7:0] == i_match_id);
        case (i_in.action)
            ACT_CLEAR:    cls_cmd.op = OP_CLEAR;
            ACT_LOAD:     cls_cmd.op = OP_LOAD;
            ACT_TRANSMIT: cls_cmd.op = OP_TX;
            ACT_FLOW:     cls_cmd.op = OP_FC;
            ACT_RECEIVE:  cls_cmd.op = OP_RX;
            default:      cls_cmd.op = OP_NONE;
        endcase
    end

    assign o_in_stall  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign push        = i_in_valid && !o_in_stall;
    assign o_cmd_valid = (r_count != '0);
    assign pop         = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_q[r_rd_ptr];

    // Queue pointer and occupancy updates.
    always_comb begin
        n_wr_ptr = push ? qptr_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = pop ? qptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Queue storage holds payload only.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cls_cmd;
        end
    end

endmodule

`default_nettype wire

[sv/dtsr_back.sv]
// Back end: request buffer, frame builder, reply reassembler and output register.
`default_nettype none

module dtsr_back
    import dtsr_pkg::*;
#(
    parameter int MAX_REQUEST_BYTES = MAX_REQUEST_BYTES_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cfg i_cfg,
    input  wire logic i_cmd_valid,
    input  wire t_cmd i_cmd,
    output logic      o_cmd_pop,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    output t_out      o_out
);

    localparam int AW = $clog2(MAX_REQUEST_BYTES);
    localparam logic [11:0] LOAD_LIMIT =
        12'((MAX_REQUEST_BYTES < 4095) ? MAX_REQUEST_BYTES : 4095);

    // Request buffer.
    logic [7:0]    mem [MAX_REQUEST_BYTES];
    logic [7:0]    r_rdata;
    logic          wr_en;
    logic          rd_en;

    // Protocol state.
    t_bstate       r_bst, n_bst;
    t_pstate       r_pst, n_pst;
    logic [11:0]   r_req_len, n_req_len;
    logic [11:0]   r_sent, n_sent;
    logic [3:0]    r_seq, n_seq;
    logic [11:0]   r_exp, n_exp;
    logic [11:0]   r_rc, n_rc;

    // Frame builder.
    logic [63:0]   r_frame, n_frame;
    logic [3:0]    r_idx, n_idx;
    logic [3:0]    r_n, n_n;
    logic [AW-1:0] r_addr, n_addr;
    logic [2:0]    r_wpos, n_wpos;
    logic          r_pend, n_pend;
    logic [2:0]    r_ppos, n_ppos;

    // Reply reassembler.
    logic [63:0]   r_rxsh, n_rxsh;
    logic [2:0]    r_left, n_left;

    // Output register.
    t_out          r_out, n_out;
    logic          r_out_valid, n_out_valid;
    logic          out_ok;

    // Transmit setup, taken from the state registers.
    logic [11:0]   tx_rem;
    logic [3:0]    tx_n;
    logic [2:0]    tx_pos;
    logic [AW-1:0] tx_addr;
    logic [11:0]   tx_sent_n;
    logic [3:0]    tx_seq_n;
    logic          tx_finish;
    logic          tx_to_fc;
    logic [63:0]   tx_frame;
    logic          tx_allowed;

    // Receive setup, taken from the queued frame.
    logic [7:0]    rx_b0, rx_b1, rx_b3;
    logic [3:0]    rx_type;
    logic          rx_gate;
    logic [11:0]   rx_ff_len;
    logic [11:0]   rx_cf_rem;
    logic [2:0]    rx_m;
    logic          rx_two;
    logic [11:0]   rx_exp_n;
    t_pstate       rx_pst_n;

    logic [11:0]   rc_inc;
    logic          status;

    assign out_ok      = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign rc_inc      = (r_rc == TOTAL_MAX) ? r_rc : r_rc + 12'd1;
    assign tx_allowed  = (r_pst == PS_READY) || (r_pst == PS_SEND_DATA);

    // Header, byte count and buffer window of the next frame.
    always_comb begin
        tx_rem    = r_req_len - r_sent;
        tx_frame  = {8{PAD_BYTE}};
        tx_n      = 4'd0;
        tx_pos    = 3'd0;
        tx_addr   = '0;
        tx_sent_n = r_sent;
        tx_seq_n  = r_seq;
        tx_finish = 1'b0;
        tx_to_fc  = 1'b0;
        if (i_cfg.use_flow_control) begin
            if (r_req_len < 12'd8) begin
                // Single frame.
                tx_frame[63:56] = {4'h0, r_req_len[3:0]};
                tx_n      = r_req_len[3:0];
                tx_pos    = 3'd1;
                tx_sent_n = r_req_len;
                tx_finish = 1'b1;
            end else if (r_sent == 12'd0) begin
                // First frame carries the 12-bit length and six bytes.
                tx_frame[63:56] = {PCI_FF, r_req_len[11:8]};
                tx_frame[55:48] = r_req_len[7:0];
                tx_n      = 4'd6;
                tx_pos    = 3'd2;
                tx_sent_n = 12'd6;
                tx_to_fc  = 1'b1;
            end else if (r_sent <= r_req_len) begin
                // Consecutive frame.
                tx_frame[63:56] = {PCI_CF, r_seq};
                tx_n      = (tx_rem > 12'd7) ? 4'd7 : tx_rem[3:0];
                tx_pos    = 3'd1;
                tx_addr   = r_sent[AW-1:0];
                tx_sent_n = r_sent + {8'd0, tx_n};
                tx_seq_n  = r_seq + 4'd1;
                tx_finish = (tx_rem <= 12'd7);
            end else begin
                tx_finish = 1'b1;
            end
        end else begin
            // Raw copy of the first bytes, no header.
            tx_n      = (r_req_len < 12'd8) ? r_req_len[3:0] : 4'd8;
            tx_sent_n = r_sent + {8'd0, tx_n};
            tx_finish = 1'b1;
        end
    end

    // Frame type decode and byte count of a received frame.
    always_comb begin
        rx_b0     = i_cmd.rx_data[63:56];
        rx_b1     = i_cmd.rx_data[55:48];
        rx_b3     = i_cmd.rx_data[39:32];
        rx_type   = rx_b0[7:4];
        rx_ff_len = {rx_b0[3:0], rx_b1};
        rx_cf_rem = r_exp - r_rc;
        rx_gate   = i_cmd.id_match &&
                    ((r_pst == PS_AWAIT_REPLY) || ((r_pst == PS_AWAIT_FC) && (rx_type == PCI_FC)));
        rx_m      = 3'd0;
        rx_two    = 1'b0;
        rx_exp_n  = r_exp;
        rx_pst_n  = r_pst;
        if (rx_gate) begin
            case (rx_type)
                PCI_SF: begin
                    // A still-pending negative response is dropped entirely.
                    if (!((rx_b1 == NEG_RESPONSE) && (rx_b0[3:0] == 4'd3) &&
                          (rx_b3 == NRC_PENDING))) begin
                        rx_exp_n = {8'd0, rx_b0[3:0]};
                        rx_pst_n = (rx_b1 == NEG_RESPONSE) ? PS_ERROR : PS_COMPLETED;
                        rx_m     = (rx_b0[3:0] > 4'd7) ? 3'd7 : rx_b0[2:0];
                    end
                end
                PCI_FF: begin
                    rx_exp_n = rx_ff_len;
                    rx_two   = 1'b1;
                    if (rx_ff_len < 12'd6) begin
                        rx_pst_n = PS_COMPLETED;
                        rx_m     = rx_ff_len[2:0];
                    end else begin
                        rx_pst_n = PS_SEND_FC;
                        rx_m     = 3'd6;
                    end
                end
                PCI_CF: begin
                    if (r_rc >= r_exp) begin
                        rx_pst_n = PS_COMPLETED;
                    end else begin
                        rx_m = (rx_cf_rem > 12'd7) ? 3'd7 : rx_cf_rem[2:0];
                        if (rx_cf_rem <= 12'd7) begin
                            rx_pst_n = PS_COMPLETED;
                        end
                    end
                end
                PCI_FC: begin
                    rx_pst_n = PS_SEND_DATA;
                end
                default: begin
                end
            endcase
        end
    end

    // Sequencer: next state and results.
    always_comb begin
        n_bst       = r_bst;
        n_pst       = r_pst;
        n_req_len   = r_req_len;
        n_sent      = r_sent;
        n_seq       = r_seq;
        n_exp       = r_exp;
        n_rc        = r_rc;
        n_frame     = r_frame;
        n_idx       = r_idx;
        n_n         = r_n;
        n_addr      = r_addr;
        n_wpos      = r_wpos;
        n_pend      = 1'b0;
        n_ppos      = r_ppos;
        n_rxsh      = r_rxsh;
        n_left      = r_left;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd_pop   = 1'b0;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        status      = 1'b0;

        case (r_bst)
            BS_IDLE: begin
                if (i_cmd_valid && out_ok) begin
                    o_cmd_pop = 1'b1;
                    case (i_cmd.op)
                        OP_CLEAR: begin
                            n_req_len = 12'd0;
                            n_sent    = 12'd0;
                            n_seq     = 4'd1;
                            n_exp     = 12'd0;
                            n_rc      = 12'd0;
                            n_pst     = PS_READY;
                            status    = 1'b1;
                        end
                        OP_LOAD: begin
                            if (r_req_len < LOAD_LIMIT) begin
                                wr_en     = 1'b1;
                                n_req_len = r_req_len + 12'd1;
                            end
                            status = 1'b1;
                        end
                        OP_TX: begin
                            if (tx_allowed) begin
                                n_frame = tx_frame;
                                n_idx   = 4'd0;
                                n_n     = tx_n;
                                n_addr  = tx_addr;
                                n_wpos  = tx_pos;
                                n_sent  = tx_sent_n;
                                n_seq   = tx_seq_n;
                                if (tx_finish) begin
                                    n_pst = i_cfg.await_response ? PS_AWAIT_REPLY
                                                                 : PS_COMPLETED;
                                end else if (tx_to_fc) begin
                                    n_pst = PS_AWAIT_FC;
                                end
                                n_bst = BS_TX;
                            end else begin
                                status = 1'b1;
                            end
                        end
                        OP_FC: begin
                            n_pst                  = PS_AWAIT_REPLY;
                            n_out                  = '0;
                            n_out.frame_valid      = 1'b1;
                            n_out.frame_id         = i_cfg.request_id;
                            n_out.frame_len        = FRAME_LEN_FC;
                            n_out.frame_data       = {FC_CLEAR_SEND, 56'd0};
                            n_out.state_out        = PS_AWAIT_REPLY;
                            n_out.last             = 1'b1;
                            n_out_valid            = 1'b1;
                        end
                        OP_RX: begin
                            n_exp = rx_exp_n;
                            n_pst = rx_pst_n;
                            if (rx_m != 3'd0) begin
                                n_left = rx_m;
                                n_rxsh = rx_two ? {i_cmd.rx_data[47:0], 16'd0}
                                                : {i_cmd.rx_data[55:0], 8'd0};
                                n_bst  = BS_RX;
                            end else begin
                                status = 1'b1;
                            end
                        end
                        default: begin
                            status = 1'b1;
                        end
                    endcase
                end
            end
            BS_TX: begin
                // One buffer read issued per cycle, its data landing in the next cycle.
                if (r_idx != r_n) begin
                    rd_en  = 1'b1;
                    n_addr = r_addr + 1'b1;
                    n_idx  = r_idx + 4'd1;
                    n_wpos = r_wpos + 3'd1;
                    n_pend = 1'b1;
                    n_ppos = r_wpos;
                end
                if (r_pend) begin
                    for (int b = 0; b < 8; b++) begin
                        if (3'(b) == r_ppos) begin
                            n_frame[63 - 8 * b -: 8] = r_rdata;
                        end
                    end
                end
                if ((r_idx == r_n) && !r_pend && out_ok) begin
                    n_out             = '0;
                    n_out.frame_valid = 1'b1;
                    n_out.frame_id    = i_cfg.request_id;
                    n_out.frame_len   = FRAME_LEN_DATA;
                    n_out.frame_data  = r_frame;
                    n_out.state_out   = r_pst;
                    n_out.last        = 1'b1;
                    n_out_valid       = 1'b1;
                    n_bst             = BS_IDLE;
                end
            end
            BS_RX: begin
                // One reply byte per accepted output slot.
                if (out_ok) begin
                    n_rc                   = rc_inc;
                    n_out                  = '0;
                    n_out.reply_byte_valid = 1'b1;
                    n_out.reply_byte       = r_rxsh[63:56];
                    n_out.received_total   = rc_inc;
                    n_out.state_out        = r_pst;
                    n_out.last             = (r_left == 3'd1);
                    n_out_valid            = 1'b1;
                    n_rxsh                 = {r_rxsh[55:0], 8'd0};
                    n_left                 = r_left - 3'd1;
                    if (r_left == 3'd1) begin
                        n_bst = BS_IDLE;
                    end
                end
            end
            default: begin
                n_bst = BS_IDLE;
            end
        endcase

        // Items without a frame or reply byte report status only.
        if (status) begin
            n_out           = '0;
            n_out.state_out = n_pst;
            n_out.last      = 1'b1;
            n_out_valid     = 1'b1;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bst       <= BS_IDLE;
            r_pst       <= PS_READY;
            r_req_len   <= 12'd0;
            r_sent      <= 12'd0;
            r_seq       <= 4'd1;
            r_exp       <= 12'd0;
            r_rc        <= 12'd0;
            r_idx       <= 4'd0;
            r_n         <= 4'd0;
            r_pend      <= 1'b0;
            r_left      <= 3'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_bst       <= n_bst;
            r_pst       <= n_pst;
            r_req_len   <= n_req_len;
            r_sent      <= n_sent;
            r_seq       <= n_seq;
            r_exp       <= n_exp;
            r_rc        <= n_rc;
            r_idx       <= n_idx;
            r_n         <= n_n;
            r_pend      <= n_pend;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_frame <= n_frame;
        r_addr  <= n_addr;
        r_wpos  <= n_wpos;
        r_ppos  <= n_ppos;
        r_rxsh  <= n_rxsh;
        r_out   <= n_out;
    end

    // Request buffer: one write and one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_req_len[AW-1:0]] <= i_cmd.request_byte;
        end
        if (rd_en) begin
            r_rdata <= mem[r_addr];
        end
    end

endmodule

`default_nettype wire

[sv/diag_transport_segmenter_reassembler.sv]
// Top level of the transport segmenter and reassembler with its configuration registers.
//
// Usage: input transactions (clear, load byte, transmit, flow control, receive)
// enter on i_in under i_in_valid / o_in_stall; results leave on o_out under
// o_out_valid / i_out_stall. A transaction is taken at an edge with valid high
// and stall low. Configuration is written through i_cfg_we / i_cfg_idx /
// i_cfg_data while no transaction is in flight.
// Path: a status or flow-control result is registered in the queue and then in
// the output register; a reply byte also passes the reply shift register, and a
// transmitted frame the buffer reads of the frame builder, 0 to 8 request bytes.
// Throughput: a transmit holds the back end while the single read port of the
// request buffer fetches its bytes; a receive gives one reply byte per cycle through
// the output register while the receiver does not stall; other transactions give one
// result each. A two-entry queue in front lets input be taken while the back end works.
// Reset (i_rst_n low, synchronous) empties the queue and output register,
// clears the request and reply, and loads the register reset values.
// When the receiver stalls, the output holds and the back end waits; input
// is still taken until the queue is full.
`default_nettype none

module diag_transport_segmenter_reassembler
    import dtsr_pkg::*;
#(
    parameter int MAX_REQUEST_BYTES = MAX_REQUEST_BYTES_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire t_in                   i_in,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output t_out                       o_out,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg r_cfg;
    logic cmd_valid;
    t_cmd cmd;
    logic cmd_pop;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.request_id       <= 11'd0;
            r_cfg.await_response   <= 1'b1;
            r_cfg.use_flow_control <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_REQUEST_ID:     r_cfg.request_id       <= i_cfg_data;
                CFG_AWAIT_RESPONSE: r_cfg.await_response   <= i_cfg_data[0];
                CFG_USE_FLOW_CTRL:  r_cfg.use_flow_control <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    dtsr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .i_match_id  (r_cfg.request_id[7:0]),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    dtsr_back #(
        .MAX_REQUEST_BYTES (MAX_REQUEST_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

[sv/dtsr_checker.sv]
// Port-level checker of the transport segmenter and reassembler, bound to the top level.
`default_nettype none

`include "diag_transport_segmenter_reassembler_assert.svh"

module dtsr_checker
    import dtsr_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic o_in_stall,
    input wire logic o_out_valid,
    input wire logic i_out_stall,
    input wire t_out o_out
);

    // Reset leaves no result pending and the queue open.
    `DTSR_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_out_valid && !o_in_stall, "reset left output or queue busy")

    // A stalled result holds.
    `DTSR_ASSERT(a_stall_hold, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out), "stalled result changed")

    // A frame result ends its transaction, carries no reply byte and has a legal length.
    `DTSR_ASSERT(a_frame_shape, o_out_valid && o_out.frame_valid |-> o_out.last && !o_out.reply_byte_valid && (o_out.frame_len == FRAME_LEN_DATA || o_out.frame_len == FRAME_LEN_FC), "malformed frame result")

    // A flow-control frame leaves the protocol awaiting the reply.
    `DTSR_ASSERT(a_fc_state, o_out_valid && o_out.frame_valid && o_out.frame_len == FRAME_LEN_FC |-> o_out.state_out == PS_AWAIT_REPLY, "flow control without await reply")

    // Every reply byte has been counted.
    `DTSR_ASSERT(a_reply_counted, o_out_valid && o_out.reply_byte_valid |-> o_out.received_total != 12'd0, "reply byte with zero total")

endmodule

bind diag_transport_segmenter_reassembler dtsr_checker u_dtsr_checker (.*);

`default_nettype wire

[tb/diag_transport_segmenter_reassembler_test.sv]
// Testbench of the transport segmenter and reassembler, checked by a built-in predictor.
`timescale 1ns / 100ps

module diag_transport_segmenter_reassembler_test;
    import dtsr_pkg::*;

    // Highest action code the field can carry; codes above receive are reserved.
    localparam logic [2:0] ACT_LAST     = 3'd7;
    localparam int         LOAD_LIMIT   = (MAX_REQUEST_BYTES_DEF < 4095) ?
                                          MAX_REQUEST_BYTES_DEF : 4095;
    localparam int         RANDOM_ITEMS = 300;
    localparam int         SETTLE       = 20;
    localparam int         TIMEOUT_NS   = 5_000_000;

    // Predicts the endpoint behavior and holds the results still owed by the block.
    class transport_scoreboard;
        bit [7:0]    request_bytes [MAX_REQUEST_BYTES_DEF];
        bit [11:0]   request_len;
        bit [11:0]   sent_len;
        bit [3:0]    next_seq;
        bit [11:0]   expected_reply_len;
        bit [11:0]   reply_count;
        t_pstate     pstate;
        bit [10:0]   request_id;
        bit          await_response;
        bit          use_flow_control;
        t_out        item_results[$];
        t_out        results_due[$];
        int unsigned errors;

        function new();
            clear_request();
            request_id       = '0;
            await_response   = 1'b1;
            use_flow_control = 1'b1;
            errors           = 0;
        endfunction

        function void clear_request();
            request_len        = '0;
            sent_len           = '0;
            next_seq           = 4'd1;
            expected_reply_len = '0;
            reply_count        = '0;
            pstate             = PS_READY;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_REQUEST_ID:     request_id = value[10:0];
                CFG_AWAIT_RESPONSE: await_response = value[0];
                CFG_USE_FLOW_CTRL:  use_flow_control = value[0];
                default: ;
            endcase
        endfunction

        function void finish_send();
            pstate = await_response ? PS_AWAIT_REPLY : PS_COMPLETED;
        endfunction

        // Builds the next outgoing data frame and advances the segmentation.
        function bit [63:0] next_tx_frame();
            bit [7:0] d [8];
            int       k;
            int       n;
            for (k = 0; k < 8; k++) d[k] = PAD_BYTE;
            if (use_flow_control) begin
                if (request_len < 8) begin
                    d[0] = {PCI_SF, request_len[3:0]};
                    for (k = 0; k < request_len; k++) d[k + 1] = request_bytes[k];
                    sent_len = request_len;
                end else if (sent_len == 0) begin
                    d[0] = {PCI_FF, request_len[11:8]};
                    d[1] = request_len[7:0];
                    for (k = 0; k < 6; k++) d[k + 2] = request_bytes[k];
                    sent_len = 12'd6;
                    pstate   = PS_AWAIT_FC;
                end else if (sent_len <= request_len) begin
                    d[0] = {PCI_CF, next_seq};
                    n = 0;
                    for (k = sent_len; k < request_len && n < 7; k++) begin
                        d[n + 1] = request_bytes[k];
                        n++;
                    end
                    sent_len = sent_len + n;
                    next_seq = next_seq + 4'd1;
                end
                if (sent_len >= request_len) finish_send();
            end else begin
                // Raw mode copies up to eight bytes without a header.
                n = (request_len < 8) ? request_len : 8;
                for (k = 0; k < n; k++) d[k] = request_bytes[k];
                sent_len = sent_len + n;
                finish_send();
            end
            return {d[0], d[1], d[2], d[3], d[4], d[5], d[6], d[7]};
        endfunction

        function void add_reply_byte(bit [7:0] value);
            t_out r;
            if (reply_count < TOTAL_MAX) reply_count++;
            r                  = '0;
            r.reply_byte_valid = 1'b1;
            r.reply_byte       = value;
            r.received_total   = reply_count;
            item_results.push_back(r);
        endfunction

        // Handles one received frame and collects the reply bytes it delivers.
        function void absorb_rx_frame(logic [28:0] id, logic [63:0] data);
            bit [7:0] b [8];
            int       k;
            int       n;
            for (k = 0; k < 8; k++) b[k] = data[63 - 8 * k -: 8];
            if (id[7:0] != request_id[7:0]) return;
            if (!(pstate == PS_AWAIT_REPLY || (pstate == PS_AWAIT_FC && b[0][7:4] == PCI_FC)))
                return;
            case (b[0][7:4])
                PCI_SF: begin
                    n = b[0][3:0];
                    // A still-pending negative response leaves everything untouched.
                    if (b[1] == NEG_RESPONSE && n == 3 && b[3] == NRC_PENDING) return;
                    expected_reply_len = n;
                    pstate = (b[1] == NEG_RESPONSE) ? PS_ERROR : PS_COMPLETED;
                    if (n > 7) n = 7;
                    for (k = 1; k <= n; k++) add_reply_byte(b[k]);
                end
                PCI_FF: begin
                    expected_reply_len = {b[0][3:0], b[1]};
                    pstate = PS_SEND_FC;
                    for (k = 2; k < 8; k++) begin
                        if (k - 2 >= expected_reply_len) begin
                            pstate = PS_COMPLETED;
                            break;
                        end
                        add_reply_byte(b[k]);
                    end
                end
                PCI_CF: begin
                    for (k = 1; k < 8; k++) begin
                        if (reply_count >= expected_reply_len) break;
                        add_reply_byte(b[k]);
                    end
                    if (reply_count >= expected_reply_len) pstate = PS_COMPLETED;
                end
                PCI_FC: pstate = PS_SEND_DATA;
                default: ;
            endcase
        endfunction

        // Notes an accepted input transaction and queues the results it causes.
        function void note_transaction(t_in x);
            t_out r;
            bit   frame;
            int   k;
            item_results = {};
            r            = '0;
            frame        = 1'b0;
            case (x.action)
                ACT_CLEAR: clear_request();
                ACT_LOAD: begin
                    if (request_len < LOAD_LIMIT) begin
                        request_bytes[request_len] = x.request_byte;
                        request_len++;
                    end
                end
                ACT_TRANSMIT: begin
                    if (pstate == PS_READY || pstate == PS_SEND_DATA) begin
                        r.frame_data = next_tx_frame();
                        r.frame_len  = FRAME_LEN_DATA;
                        frame        = 1'b1;
                    end
                end
                ACT_FLOW: begin
                    pstate       = PS_AWAIT_REPLY;
                    r.frame_data = {FC_CLEAR_SEND, 56'h0};
                    r.frame_len  = FRAME_LEN_FC;
                    frame        = 1'b1;
                end
                ACT_RECEIVE: absorb_rx_frame(x.rx_id, x.rx_data);
                default: ;
            endcase
            if (frame) begin
                r.frame_valid = 1'b1;
                r.frame_id    = request_id;
                item_results.push_back(r);
            end else if (item_results.size() == 0) begin
                item_results.push_back(r);
            end
            for (k = 0; k < item_results.size(); k++) begin
                r           = item_results[k];
                r.state_out = pstate;
                r.last      = (k == item_results.size() - 1);
                results_due.push_back(r);
            end
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                if (errors < 40)
                    $display("%0t: %s expected %h actual %h", $time, name, want, got);
                errors++;
            end
        endfunction

        // Checks one accepted result transaction against the oldest one owed.
        function void check_transaction(t_out got);
            t_out want;
            if (results_due.size() == 0) begin
                if (errors < 40)
                    $display("%0t: result %h arrived with none expected", $time, got);
                errors++;
                return;
            end
            want = results_due.pop_front();
            compare_field("frame_valid", want.frame_valid, got.frame_valid);
            compare_field("frame_id", want.frame_id, got.frame_id);
            compare_field("frame_len", want.frame_len, got.frame_len);
            compare_field("frame_data", want.frame_data, got.frame_data);
            compare_field("reply_byte_valid", want.reply_byte_valid, got.reply_byte_valid);
            compare_field("reply_byte", want.reply_byte, got.reply_byte);
            compare_field("received_total", want.received_total, got.received_total);
            compare_field("state_out", want.state_out, got.state_out);
            compare_field("last", want.last, got.last);
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in                   i_in;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out                  o_out;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    transport_scoreboard sb = new();
    int unsigned         cycle_no = 0;
    int unsigned         items_done = 0;
    logic                quiet;

    diag_transport_segmenter_reassembler u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // One window in four runs with no idling on either side.
    assign quiet = (cycle_no % 4000) >= 3000;

    // Receiver side: random stalls of the result channel.
    always @(posedge i_clk) begin
        cycle_no    <= cycle_no + 1;
        i_out_stall <= !quiet && ($urandom_range(99) < 20);
    end

    // Every accepted result transaction goes to the scoreboard.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0)
            sb.check_transaction(o_out);
    end

    initial begin
        #(TIMEOUT_NS);
        $display("tb: failure");
        $finish;
    end

    function automatic t_in make_item(logic [2:0] action);
        t_in x;
        x.action       = action;
        x.request_byte = $urandom;
        x.rx_id        = $urandom;
        x.rx_data      = {$urandom, $urandom};
        return x;
    endfunction

    function automatic logic [63:0] frame_bytes(logic [3:0] pci);
        logic [63:0] d;
        d          = {$urandom, $urandom};
        d[63:60]   = pci;
        return d;
    endfunction

    // Received frame whose identifier matches the request id or deliberately misses it.
    function automatic t_in rx_frame(bit hit, logic [63:0] data);
        t_in x;
        x         = make_item(ACT_RECEIVE);
        x.rx_data = data;
        if (hit) x.rx_id[7:0] = sb.request_id[7:0];
        else     x.rx_id[7:0] = sb.request_id[7:0] ^ 8'($urandom_range(1, 255));
        return x;
    endfunction

    function automatic t_in stray_item();
        if ($urandom_range(1)) return make_item(ACT_RECEIVE);
        return make_item(3'($urandom_range(ACT_RECEIVE + 1, ACT_LAST)));
    endfunction

    // Offers one input transaction and waits until the block takes it.
    task automatic send(t_in x);
        while (!quiet && $urandom_range(99) < 20) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= x;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        if (x.action <= ACT_RECEIVE &&
            !(x.action == ACT_RECEIVE && x.rx_id[7:0] != sb.request_id[7:0]))
            items_done++;
        sb.note_transaction(x);
    endtask

    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        while (sb.results_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        sb.set_register(idx, value);
    endtask

    task automatic apply_settings(logic [10:0] id, logic await_on, logic segmented);
        wait_results_drained();
        write_register(CFG_REQUEST_ID, id);
        write_register(CFG_AWAIT_RESPONSE, await_on);
        write_register(CFG_USE_FLOW_CTRL, segmented);
        i_cfg_we <= 1'b0;
    endtask

    // A full request and reply: load, segment under flow control, then answer.
    task automatic run_exchange(int n_bytes, bit full_reply);
        logic [63:0] d;
        int          len;
        int          pick;
        send(make_item(ACT_CLEAR));
        repeat (n_bytes) send(make_item(ACT_LOAD));
        while (sb.pstate == PS_READY || sb.pstate == PS_SEND_DATA ||
               sb.pstate == PS_AWAIT_FC) begin
            if ($urandom_range(11) == 0)        send(stray_item());
            else if (sb.pstate == PS_AWAIT_FC)  send(rx_frame(1, frame_bytes(PCI_FC)));
            else                                send(make_item(ACT_TRANSMIT));
        end
        if (sb.pstate != PS_AWAIT_REPLY) return;
        pick = $urandom_range(9);
        if (!full_reply && pick < 4) begin
            // Single frame answer, at times preceded by a pending notice or itself negative.
            if (pick == 0) begin
                d          = frame_bytes(PCI_SF);
                d[59:56]   = 4'd3;
                d[55:48]   = NEG_RESPONSE;
                d[39:32]   = NRC_PENDING;
                send(rx_frame(1, d));
            end
            d        = frame_bytes(PCI_SF);
            d[59:56] = ($urandom_range(7) == 0) ? $urandom_range(8, 15) : $urandom_range(7);
            if (pick == 1) d[55:48] = NEG_RESPONSE;
            send(rx_frame(1, d));
        end else begin
            if (full_reply)                 len = TOTAL_MAX;
            else if ($urandom_range(3) == 0) len = $urandom_range(5);
            else                            len = $urandom_range(6, 80);
            d        = frame_bytes(PCI_FF);
            d[59:48] = len;
            send(rx_frame(1, d));
            while (sb.pstate == PS_SEND_FC || sb.pstate == PS_AWAIT_REPLY) begin
                if ($urandom_range(15) == 0)       send(rx_frame(0, frame_bytes(PCI_CF)));
                else if (sb.pstate == PS_SEND_FC)  send(make_item(ACT_FLOW));
                else                               send(rx_frame(1, frame_bytes(PCI_CF)));
            end
        end
        // A late consecutive frame after completion must be dropped.
        if ($urandom_range(3) == 0) send(rx_frame(1, frame_bytes(PCI_CF)));
    endtask

    initial begin
        t_in         x;
        int unsigned random_start;
        int          round;
        int          a;
        logic [10:0] id;

        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in       <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= '0;
        i_cfg_data <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reserved actions, wrong-state transmit, receive gating and
        // special reply frames, then a two-frame request under flow control.
        for (a = ACT_RECEIVE + 1; a <= ACT_LAST; a++) send(make_item(3'(a)));
        send(make_item(ACT_TRANSMIT));
        send(make_item(ACT_TRANSMIT));
        x = make_item(ACT_RECEIVE);
        x.rx_id   = 29'h1FFFFF00;
        x.rx_data = '1;
        send(x);
        x = rx_frame(1, {PCI_SF, 4'd3, NEG_RESPONSE, 8'h22, NRC_PENDING, 32'h0});
        send(x);
        x = make_item(ACT_RECEIVE);
        x.rx_id   = 29'h1FFFFFFF;
        x.rx_data = {PCI_SF, 4'd2, 56'h0};
        send(x);
        x = make_item(ACT_RECEIVE);
        x.rx_id   = '0;
        x.rx_data = {PCI_SF, 60'hFFF_FFFF_FFFF_FFFF};
        send(x);
        send(make_item(ACT_FLOW));
        send(rx_frame(1, {PCI_SF, 4'd3, NEG_RESPONSE, 8'h31, 8'h10, 32'h0}));
        send(make_item(ACT_CLEAR));
        x = make_item(ACT_LOAD);
        x.request_byte = 8'h00;
        send(x);
        x.request_byte = 8'hFF;
        send(x);
        repeat (6) send(make_item(ACT_LOAD));
        send(make_item(ACT_TRANSMIT));
        send(rx_frame(1, frame_bytes(PCI_SF)));
        send(rx_frame(1, {FC_CLEAR_SEND, 56'h0}));
        send(make_item(ACT_TRANSMIT));
        send(rx_frame(1, {PCI_FF, 12'd3, 48'h0102_0304_0506}));
        send(make_item(ACT_TRANSMIT));

        // Longest request past the buffer limit, answered by the longest reply.
        apply_settings(11'h7FF, 1'b1, 1'b1);
        run_exchange(LOAD_LIMIT + 5, 1'b1);

        // Random exchanges and noise under changing settings.
        apply_settings(11'h000, 1'b0, 1'b0);
        random_start = items_done;
        round        = 0;
        while (items_done - random_start < RANDOM_ITEMS) begin
            if (round % 2 == 1) begin
                case ($urandom_range(2))
                    0:       id = 11'h000;
                    1:       id = 11'h7FF;
                    default: id = $urandom;
                endcase
                apply_settings(id, $urandom_range(1), $urandom_range(3) != 0);
            end
            if ($urandom_range(3) != 0) begin
                run_exchange(($urandom_range(9) == 0) ? $urandom_range(15, 60)
                                                      : $urandom_range(14), 1'b0);
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    x = make_item(3'($urandom_range(ACT_LAST)));
                    if ($urandom_range(1)) x.rx_id[7:0] = sb.request_id[7:0];
                    send(x);
                end
            end
            round++;
        end

        wait_results_drained();
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[diag_transport_segmenter_reassembler.f]
+incdir+sv
sv/dtsr_pkg.sv
sv/dtsr_front.sv
sv/dtsr_back.sv
sv/diag_transport_segmenter_reassembler.sv
sv/dtsr_checker.sv
tb/diag_transport_segmenter_reassembler_test.sv
